FILE: src/ssfl_pkg.sv
// Shared types, constants and helpers for the streaming substring search.
// No dependencies; every other file of the block imports this package.
package ssfl_pkg;

  // Pattern storage and position counter sizing
  localparam int unsigned PatternMax = 16;
  localparam int unsigned PosWidth   = 16;
  localparam int unsigned IdxWidth   = 16;
  localparam int unsigned LenWidth   = 5;
  localparam int unsigned PatWidth   = 128;
  localparam int unsigned PmIdxWidth = (PatternMax > 1) ? $clog2(PatternMax) : 1;

  typedef logic [PatternMax-1:0] pmvec_t;
  typedef logic [PosWidth-1:0]   pos_t;
  typedef logic [LenWidth-1:0]   len_t;

  localparam pos_t PosMax = '1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgPatLow  = 2'd0,
    CfgPatHigh = 2'd1,
    CfgPatLen  = 2'd2
  } cfg_idx_e;

  // Input request and result payloads
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [IdxWidth-1:0] first_index;
    logic [IdxWidth-1:0] last_index;
    logic                overflow;
  } rsp_t;

  // Classified byte handed from front to back
  typedef struct packed {
    pmvec_t eq;
    logic   last;
  } cmd_t;

  // Active configuration (length already clamped to 1..PatternMax)
  typedef struct packed {
    logic [PatWidth-1:0] pattern;
    len_t                len;
  } cfg_t;

  // Clamp a raw length register value into 1..PatternMax
  function automatic len_t eff_len(input len_t raw);
    len_t res;
    res = raw;
    if (raw == '0) begin
      res = len_t'(1);
    end else if (raw > len_t'(PatternMax)) begin
      res = len_t'(PatternMax);
    end
    return res;
  endfunction

endpackage

FILE: src/ssfl_front.sv
// Front end: compares each text byte against all pattern bytes at once and
// queues the match vector for the back end. Depends on ssfl_pkg.
module ssfl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ssfl_pkg::cfg_t  cfg_i,
  input  ssfl_pkg::req_t  req_i,
  input  logic            push_i,
  output logic            full_o,
  output logic            cmd_valid_o,
  output ssfl_pkg::cmd_t  cmd_o,
  input  logic            cmd_ready_i
);
  import ssfl_pkg::*;

  cmd_t       cmd_in;
  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  // Classify: one equality bit per active pattern position
  always_comb begin
    cmd_in.last = req_i.last_byte;
    for (int i = 0; i < PatternMax; i++) begin
      cmd_in.eq[i] = (len_t'(i) < cfg_i.len) &&
                     (cfg_i.pattern[i*8 +: 8] == req_i.text_byte);
    end
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_o = entry_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("front queue occupancy out of range");
  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("front queue lost a request");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("front queue pointers out of step");
`endif

endmodule

FILE: src/ssfl_back.sv
// Back end: shift-and update of the partial-match vector, position and
// occurrence tracking, plus the result queue. Depends on ssfl_pkg.
module ssfl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ssfl_pkg::len_t  len_i,
  input  logic            cmd_valid_i,
  input  ssfl_pkg::cmd_t  cmd_i,
  output logic            cmd_ready_o,
  output logic            empty_o,
  output ssfl_pkg::rsp_t  rsp_o,
  input  logic            pop_i
);
  import ssfl_pkg::*;

  pmvec_t     pm_q, pm_d;
  pos_t       pos_q, pos_d;
  logic       seen_q, seen_d;
  pos_t       first_q, first_d;
  pos_t       last_q, last_d;
  logic       ovf_q, ovf_d;

  rsp_t       res_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       res_full;
  logic       res_push, res_pop, take;

  pmvec_t     pm_next;
  pos_t       idx, start;
  logic       sat, hit, seen_n, ovf_n;
  pos_t       first_n, last_n;
  logic [PmIdxWidth-1:0] top_bit;
  rsp_t       rsp_new;

  assign res_full    = (cnt_q == 2'd2);
  assign cmd_ready_o = !cmd_i.last || !res_full;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign res_push    = take && cmd_i.last;
  assign res_pop     = pop_i && !empty_o;

  // Match update for the byte at the head of the queue
  always_comb begin
    sat     = (pos_q == PosMax);
    idx     = pos_q;
    ovf_n   = ovf_q || sat;
    pm_next = {pm_q[PatternMax-2:0], 1'b1} & cmd_i.eq;
    top_bit = PmIdxWidth'(len_i - len_t'(1));
    hit     = pm_next[top_bit];
    start   = idx - pos_t'(len_i - len_t'(1));
    seen_n  = seen_q || hit;
    first_n = (hit && !seen_q) ? start : first_q;
    last_n  = hit ? start : last_q;

    rsp_new.found       = seen_n;
    rsp_new.first_index = seen_n ? IdxWidth'(first_n) : '0;
    rsp_new.last_index  = seen_n ? IdxWidth'(last_n) : '0;
    rsp_new.overflow    = ovf_n;
  end

  // Advance or clear per-text state
  always_comb begin
    pm_d    = pm_q;
    pos_d   = pos_q;
    seen_d  = seen_q;
    first_d = first_q;
    last_d  = last_q;
    ovf_d   = ovf_q;
    if (take) begin
      if (cmd_i.last) begin
        pm_d    = '0;
        pos_d   = '0;
        seen_d  = 1'b0;
        first_d = '0;
        last_d  = '0;
        ovf_d   = 1'b0;
      end else begin
        pm_d    = pm_next;
        pos_d   = sat ? pos_q : pos_q + pos_t'(1);
        seen_d  = seen_n;
        first_d = first_n;
        last_d  = last_n;
        ovf_d   = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q    <= '0;
      pos_q   <= '0;
      seen_q  <= 1'b0;
      first_q <= '0;
      last_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      pm_q    <= pm_d;
      pos_q   <= pos_d;
      seen_q  <= seen_d;
      first_q <= first_d;
      last_q  <= last_d;
      ovf_q   <= ovf_d;
    end
  end

  // Result queue control
  assign cnt_d = cnt_q + {1'b0, res_push} - {1'b0, res_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ res_push;
      rd_ptr_q <= rd_ptr_q ^ res_pop;
      cnt_q    <= cnt_d;
    end
  end

  // Hold waiting results
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[wr_ptr_q] <= rsp_new;
    end
  end

  assign empty_o = (cnt_q == 2'd0);
  assign rsp_o   = res_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("result queue occupancy out of range");
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> pos_q == PosMax) else $error("overflow without saturated position");
  a_no_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (first_q == '0 && last_q == '0))
    else $error("occurrence start recorded without a match");
  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> (pos_q == '0 && pm_q == '0 && !seen_q && !ovf_q))
    else $error("per-text state not cleared after last byte");
`endif

endmodule

FILE: src/substring_search_first_last.sv
// Top level of the streaming substring search: configuration registers and
// the front/back split. Depends on ssfl_pkg, ssfl_front and ssfl_back.
//
//   channel  direction  handshake            payload
//   request  in         push_i / full_o      req_i  (text_byte, last_byte)
//   result   out        pop_i / empty_o      rsp_o  (found, indices, overflow)
//   config   in         cfg_valid_i/ready_o  cfg_index_i, cfg_data_i
//
// One text byte is taken per cycle unless full_o is set; classified bytes
// pass through the front queue register to the back end, and a result is
// queued once its last byte is processed there. Both internal queues hold
// two entries, so a full result queue stalls only last bytes. Reset clears
// the pattern to zero, the length to one; the config port is always ready.
module substring_search_first_last (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  ssfl_pkg::req_t        req_i,
  output logic                  empty_o,
  input  logic                  pop_i,
  output ssfl_pkg::rsp_t        rsp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [63:0]           cfg_data_i
);
  import ssfl_pkg::*;

  logic [63:0] pat_low_q, pat_high_q;
  len_t        pat_len_q;
  cfg_t        cfg;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers; unknown indexes drop the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= len_t'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPatLow:  pat_low_q  <= cfg_data_i;
        CfgPatHigh: pat_high_q <= cfg_data_i;
        CfgPatLen:  pat_len_q  <= cfg_data_i[LenWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern = {pat_high_q, pat_low_q};
  assign cfg.len     = eff_len(pat_len_q);

  ssfl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (req_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  ssfl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_i       (cfg.len),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .empty_o     (empty_o),
    .rsp_o       (rsp_o),
    .pop_i       (pop_i)
  );

endmodule
